// ===== sv/assert_macros.svh =====
// assertion macros shared by the priority list rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) `ASSERT_CHK(lbl, !(expr), msg)

`endif

// ===== sv/pol_pkg.sv =====
// types and constants of the priority ordered list
`default_nettype none
package pol_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W = 32;
  localparam int unsigned PRI_W = 2;
  localparam int unsigned FN_W  = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [FN_W-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_READ   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } st_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_PUT
  } state_e;

  typedef struct packed {
    logic [PRI_W-1:0]        prio;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } store_req_t;

  typedef struct packed {
    logic   done;
    st_e    status;
    entry_t rd;
    logic   inc;
    logic   dec;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/pol_store.sv =====
// entry memory with one write port and one registered read port
`default_nettype none
module pol_store (
  input  logic               clk_i,
  input  pol_pkg::store_req_t req_i,
  output pol_pkg::entry_t    rdata_o
);
  import pol_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/pol_ctrl.sv =====
// sequencer that walks the memory one entry per step to insert, remove or read
`default_nettype none
`include "assert_macros.svh"
module pol_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pol_pkg::FN_W-1:0]     func_i,
  input  logic signed [pol_pkg::VAL_W-1:0] entry_value_i,
  input  logic [pol_pkg::PRI_W-1:0]    entry_priority_i,
  input  pol_pkg::idx_t                position_i,
  input  pol_pkg::cnt_t                count_i,
  input  pol_pkg::entry_t              rdata_i,
  output pol_pkg::store_req_t          mem_o,
  output pol_pkg::res_t                res_o,
  output logic                         busy_o
);
  import pol_pkg::*;

  state_e           state_q, state_d;
  idx_t             idx_q, idx_d;
  idx_t             raddr_q, raddr_d;
  logic [FN_W-1:0]  func_q, func_d;
  entry_t           new_q, new_d;

  entry_t new_in;
  logic   full;
  logic   pos_ok;
  logic   rm_shift;
  logic   rm_more;
  logic   pri_le;

  assign new_in   = '{prio: entry_priority_i, value: entry_value_i};
  assign full     = (count_i == CNT_W'(DEPTH));
  assign pos_ok   = (CNT_W'(position_i) < count_i);
  assign rm_shift = ((CNT_W'(position_i) + CNT_W'(1)) < count_i);
  assign rm_more  = ((CNT_W'(idx_q) + CNT_W'(2)) < count_i);
  // shared compare: stored entry moves back when not above the new priority
  assign pri_le   = (rdata_i.prio <= new_q.prio);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    raddr_d = raddr_q;
    func_d  = func_q;
    new_d   = new_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d = func_i;
          new_d  = new_in;
          unique case (func_i)
            FN_INSERT: begin
              if (!full && (count_i != '0)) begin
                idx_d   = count_i[IDX_W-1:0];
                raddr_d = count_i[IDX_W-1:0] - IDX_W'(1);
                state_d = S_RD;
              end
            end
            FN_REMOVE: begin
              if (pos_ok && rm_shift) begin
                idx_d   = position_i;
                raddr_d = position_i + IDX_W'(1);
                state_d = S_RD;
              end
            end
            FN_READ: begin
              if (pos_ok) begin
                raddr_d = position_i;
                state_d = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        state_d = S_EV;
      end
      S_EV: begin
        unique case (func_q)
          FN_INSERT: begin
            if (pri_le) begin
              idx_d = idx_q - IDX_W'(1);
              if (idx_q == IDX_W'(1)) begin
                state_d = S_PUT;
              end else begin
                raddr_d = idx_q - IDX_W'(2);
                state_d = S_RD;
              end
            end else begin
              state_d = S_IDLE;
            end
          end
          FN_REMOVE: begin
            idx_d = idx_q + IDX_W'(1);
            if (rm_more) begin
              raddr_d = idx_q + IDX_W'(2);
              state_d = S_RD;
            end else begin
              state_d = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_PUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mem_o = '{we: 1'b0, waddr: idx_q, wdata: rdata_i, raddr: raddr_q};
    res_o = '{done: 1'b0, status: ST_OK, rd: '0, inc: 1'b0, dec: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (func_i)
            FN_INSERT: begin
              if (full) begin
                res_o.done   = 1'b1;
                res_o.status = ST_FULL;
              end else if (count_i == '0) begin
                mem_o.we    = 1'b1;
                mem_o.waddr = '0;
                mem_o.wdata = new_in;
                res_o.done  = 1'b1;
                res_o.inc   = 1'b1;
              end
            end
            FN_REMOVE: begin
              if (!pos_ok) begin
                res_o.done   = 1'b1;
                res_o.status = ST_RANGE;
              end else if (!rm_shift) begin
                res_o.done = 1'b1;
                res_o.dec  = 1'b1;
              end
            end
            FN_READ: begin
              if (!pos_ok) begin
                res_o.done   = 1'b1;
                res_o.status = ST_RANGE;
              end
            end
            default: res_o.done = 1'b1;
          endcase
        end
      end
      S_EV: begin
        unique case (func_q)
          FN_INSERT: begin
            mem_o.we = 1'b1;
            if (!pri_le) begin
              mem_o.wdata = new_q;
              res_o.done  = 1'b1;
              res_o.inc   = 1'b1;
            end
          end
          FN_REMOVE: begin
            mem_o.we = 1'b1;
            if (!rm_more) begin
              res_o.done = 1'b1;
              res_o.dec  = 1'b1;
            end
          end
          default: begin
            res_o.done = 1'b1;
            res_o.rd   = rdata_i;
          end
        endcase
      end
      S_PUT: begin
        mem_o.we    = 1'b1;
        mem_o.wdata = new_q;
        res_o.done  = 1'b1;
        res_o.inc   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    raddr_q <= raddr_d;
    func_q  <= func_d;
    new_q   <= new_d;
  end

  assign busy_o = (state_q != S_IDLE);

  `ASSERT_CHK(a_rd_then_ev, state_q == S_RD |=> state_q == S_EV, "read not followed by evaluate")
  `ASSERT_NEVER(a_ins_slot, state_q == S_EV && func_q == FN_INSERT && idx_q == '0, "insert step at head")
  `ASSERT_NEVER(a_done_busy, res_o.done && state_q == S_RD, "result while read pending")

endmodule
`default_nettype wire

// ===== sv/priority_ordered_list.sv =====
// top level of the priority ordered list
`default_nettype none
`include "assert_macros.svh"
// Holds up to DEPTH (16) entries of a signed 32-bit value and a 2-bit priority,
// kept in descending priority, newest first among equal priorities.
// A request is taken when start is high and busy is low: func_i selects
// insert, remove at position_i, or read at position_i.
// Each request gives one result: done_o is high for one cycle with
// read_value_o, read_priority_o, status_o and entry_count_o, and the
// receiver takes it in that cycle; it cannot hold results off.
// One sequencer walks the entry memory, which has one write port and one
// registered read port. A refused or reserved request, an insert into an
// empty list or a remove of the last entry finishes straight from idle.
// Otherwise each entry is read (S_RD) and evaluated (S_EV): a read returns
// that entry, an insert moves entries back from the tail until its slot
// is found (S_PUT writes at the head), and a remove moves entries forward.
// busy is high from the cycle after a request that walks the memory until
// done_o rises, so the next request may follow in the cycle done_o is high.
// Reset empties the list; memory contents are not cleared.
module priority_ordered_list (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [pol_pkg::FN_W-1:0]         func_i,
  input  logic signed [pol_pkg::VAL_W-1:0] entry_value_i,
  input  logic [pol_pkg::PRI_W-1:0]        entry_priority_i,
  input  logic [pol_pkg::IDX_W-1:0]        position_i,
  output logic                             done_o,
  output logic signed [pol_pkg::VAL_W-1:0] read_value_o,
  output logic [pol_pkg::PRI_W-1:0]        read_priority_o,
  output logic [1:0]                       status_o,
  output logic [pol_pkg::CNT_W-1:0]        entry_count_o
);
  import pol_pkg::*;

  store_req_t mem_req;
  entry_t     rdata;
  res_t       res;

  cnt_t   count_q, count_d;
  logic   done_q;
  entry_t rd_q;
  st_e    status_q;

  pol_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .func_i           (func_i),
    .entry_value_i    (entry_value_i),
    .entry_priority_i (entry_priority_i),
    .position_i       (position_i),
    .count_i          (count_q),
    .rdata_i          (rdata),
    .mem_o            (mem_req),
    .res_o            (res),
    .busy_o           (busy)
  );

  pol_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d = count_q;
    if (res.done && res.inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (res.done && res.dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= res.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done) begin
      rd_q     <= res.rd;
      status_q <= res.status;
    end
  end

  assign done_o          = done_q;
  assign read_value_o    = rd_q.value;
  assign read_priority_o = rd_q.prio;
  assign status_o        = status_q;
  assign entry_count_o   = count_q;

  `ASSERT_NEVER(a_cnt_max, count_q > CNT_W'(DEPTH), "count above depth")
  `ASSERT_CHK(a_done_idle, done_o |-> !busy, "result while still busy")
  `ASSERT_CHK(a_full_cnt, done_o && status_q == ST_FULL |-> count_q == CNT_W'(DEPTH), "full status below depth")

endmodule
`default_nettype wire
